>>> sv/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// Used by the controller, the datapath and the top level; no dependencies.
package sfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int CFG_IW  = 3;
    localparam int STAT_W  = 2;
    localparam int INDEX_W = 5;

    localparam logic [CFG_IW-1:0] CFG_START_MARKER = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_END_MARKER   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ACK_CODE     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_NACK_CODE    = 3'd3;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd2;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd3;
    localparam logic [BYTE_W-1:0] ACK_CODE_RST     = 8'd6;
    localparam logic [BYTE_W-1:0] NACK_CODE_RST    = 8'd21;

    // Result kind; the encoding is the status code of the result.
    typedef enum logic [STAT_W-1:0] {
        OUT_PAYLOAD = 2'd0,
        OUT_ACK     = 2'd1,
        OUT_NACK    = 2'd2,
        OUT_LONG    = 2'd3
    } out_kind_t;

    typedef enum logic [7:0] {
        S_START  = 8'b0000_0001,
        S_LENGTH = 8'b0000_0010,
        S_DATA   = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_END    = 8'b0001_0000,
        S_READ   = 8'b0010_0000,
        S_SEND   = 8'b0100_0000,
        S_ACK    = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic      clr_xor;
        logic      len_load;
        logic      data_wr;
        logic      chk_load;
        logic      idx_clr;
        logic      rd_en;
        logic      idx_inc;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic start_hit;
        logic len_long;
        logic len_zero;
        logic data_done;
        logic end_hit;
        logic xor_match;
        logic cnt_zero;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

>>> sv/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/sfr_ctrl.sv
// Frame controller state machine: sequences frame parsing and payload replay.
// Depends on sfr_pkg; drives commands to and reads status from sfr_dp.
module sfr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rx_valid,
    output logic          rx_ready,
    input  sfr_pkg::sts_t sts,
    output sfr_pkg::cmd_t cmd
);

    sfr_pkg::state_t state_reg;
    sfr_pkg::state_t state_next;
    logic            accept;

    assign rx_ready = ((state_reg == sfr_pkg::S_START) || (state_reg == sfr_pkg::S_LENGTH)
                    || (state_reg == sfr_pkg::S_DATA) || (state_reg == sfr_pkg::S_CHECK)
                    || (state_reg == sfr_pkg::S_END)) && sts.out_free;
    assign accept = rx_valid && rx_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_kind = sfr_pkg::OUT_PAYLOAD;
        unique case (state_reg)
            sfr_pkg::S_START:
            begin
                if (accept && sts.start_hit)
                begin
                    cmd.clr_xor = 1'b1;
                    state_next  = sfr_pkg::S_LENGTH;
                end
            end
            sfr_pkg::S_LENGTH:
            begin
                if (accept)
                begin
                    cmd.len_load = 1'b1;
                    if (sts.len_long)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = sfr_pkg::OUT_LONG;
                        state_next   = sfr_pkg::S_START;
                    end
                    else if (sts.len_zero)
                    begin
                        state_next = sfr_pkg::S_CHECK;
                    end
                    else
                    begin
                        state_next = sfr_pkg::S_DATA;
                    end
                end
            end
            sfr_pkg::S_DATA:
            begin
                if (accept)
                begin
                    cmd.data_wr = 1'b1;
                    if (sts.data_done)
                    begin
                        state_next = sfr_pkg::S_CHECK;
                    end
                end
            end
            sfr_pkg::S_CHECK:
            begin
                if (accept)
                begin
                    cmd.chk_load = 1'b1;
                    state_next   = sfr_pkg::S_END;
                end
            end
            sfr_pkg::S_END:
            begin
                if (accept)
                begin
                    state_next = sfr_pkg::S_START;
                    if (sts.end_hit)
                    begin
                        if (sts.xor_match)
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = sts.cnt_zero ? sfr_pkg::S_ACK : sfr_pkg::S_READ;
                        end
                        else
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = sfr_pkg::OUT_NACK;
                        end
                    end
                end
            end
            sfr_pkg::S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = sfr_pkg::S_SEND;
            end
            sfr_pkg::S_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = sfr_pkg::OUT_PAYLOAD;
                    cmd.idx_inc  = 1'b1;
                    state_next   = sts.idx_last ? sfr_pkg::S_ACK : sfr_pkg::S_READ;
                end
            end
            sfr_pkg::S_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = sfr_pkg::OUT_ACK;
                    state_next   = sfr_pkg::S_START;
                end
            end
            default:
            begin
                state_next = sfr_pkg::S_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfr_pkg::S_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/sfr_dp.sv
// Frame datapath: configuration registers, counters, checksum, payload store
// and output register. Depends on sfr_pkg and sfr_ram; commanded by sfr_ctrl.
module sfr_dp #(
    parameter int PAYLOAD_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfr_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]    cfg_data,
    input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte,
    input  sfr_pkg::cmd_t                 cmd,
    output sfr_pkg::sts_t                 sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sfr_pkg::STAT_W-1:0]    status,
    output logic [sfr_pkg::BYTE_W-1:0]    data_byte,
    output logic [sfr_pkg::INDEX_W-1:0]   byte_index,
    output logic                          send_reply,
    output logic                          last
);

    localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
    localparam int AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic [sfr_pkg::BYTE_W-1:0]  start_marker_reg;
    logic [sfr_pkg::BYTE_W-1:0]  end_marker_reg;
    logic [sfr_pkg::BYTE_W-1:0]  ack_code_reg;
    logic [sfr_pkg::BYTE_W-1:0]  nack_code_reg;
    logic [CNT_W-1:0]            exp_len_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [sfr_pkg::BYTE_W-1:0]  xor_reg;
    logic [sfr_pkg::BYTE_W-1:0]  chk_reg;
    logic                        out_valid_reg;
    logic [sfr_pkg::STAT_W-1:0]  status_reg;
    logic [sfr_pkg::BYTE_W-1:0]  data_reg;
    logic [sfr_pkg::INDEX_W-1:0] index_reg;
    logic                        reply_reg;
    logic                        last_reg;
    logic [CNT_W:0]              cnt_plus;
    logic [CNT_W:0]              idx_plus;
    logic                        store_wr;
    logic [sfr_pkg::BYTE_W-1:0]  rd_data;
    logic [sfr_pkg::BYTE_W-1:0]  out_data_next;

    assign cnt_plus = {1'b0, cnt_reg} + 1'b1;
    assign idx_plus = {1'b0, idx_reg} + 1'b1;
    assign store_wr = cmd.data_wr && (cnt_reg < CNT_W'(PAYLOAD_DEPTH));

    assign sts.start_hit = (rx_byte == start_marker_reg);
    assign sts.len_long  = (rx_byte > 8'(PAYLOAD_DEPTH));
    assign sts.len_zero  = (rx_byte == '0);
    assign sts.data_done = (cnt_plus >= {1'b0, exp_len_reg})
                        || (cnt_plus >= (CNT_W + 1)'(PAYLOAD_DEPTH));
    assign sts.end_hit   = (rx_byte == end_marker_reg);
    assign sts.xor_match = (xor_reg == chk_reg);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.idx_last  = (idx_plus == {1'b0, cnt_reg});
    assign sts.out_free  = !out_valid_reg || out_ready;

    sfr_ram #(
        .WIDTH (sfr_pkg::BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_wr),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= sfr_pkg::START_MARKER_RST;
            end_marker_reg   <= sfr_pkg::END_MARKER_RST;
            ack_code_reg     <= sfr_pkg::ACK_CODE_RST;
            nack_code_reg    <= sfr_pkg::NACK_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                sfr_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                sfr_pkg::CFG_ACK_CODE:     ack_code_reg     <= cfg_data;
                sfr_pkg::CFG_NACK_CODE:    nack_code_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            xor_reg     <= '0;
            chk_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_xor)
            begin
                xor_reg <= '0;
            end
            if (cmd.len_load)
            begin
                cnt_reg     <= '0;
                exp_len_reg <= sts.len_long ? '0 : CNT_W'(rx_byte);
            end
            if (cmd.data_wr)
            begin
                xor_reg <= xor_reg ^ rx_byte;
                if (store_wr)
                begin
                    cnt_reg <= cnt_plus[CNT_W-1:0];
                end
            end
            if (cmd.chk_load)
            begin
                chk_reg <= rx_byte;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (cmd.out_kind)
            sfr_pkg::OUT_PAYLOAD: out_data_next = rd_data;
            sfr_pkg::OUT_ACK:     out_data_next = ack_code_reg;
            sfr_pkg::OUT_NACK:    out_data_next = nack_code_reg;
            sfr_pkg::OUT_LONG:    out_data_next = rx_byte;
            default:              out_data_next = rx_byte;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_kind;
            data_reg   <= out_data_next;
            index_reg  <= (cmd.out_kind == sfr_pkg::OUT_PAYLOAD)
                        ? sfr_pkg::INDEX_W'(idx_reg) : '0;
            reply_reg  <= (cmd.out_kind == sfr_pkg::OUT_ACK)
                       || (cmd.out_kind == sfr_pkg::OUT_NACK);
            last_reg   <= (cmd.out_kind != sfr_pkg::OUT_PAYLOAD);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign data_byte  = data_reg;
    assign byte_index = index_reg;
    assign send_reply = reply_reg;
    assign last       = last_reg;

endmodule

>>> sv/serial_frame_receiver_top.sv
// Top level of the serial frame receiver: controller plus datapath.
// Depends on sfr_pkg, sfr_ctrl, sfr_dp (and sfr_ram through sfr_dp).
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid/rx_ready    rx_byte
//   out      out        out_valid/out_ready  status, data_byte, byte_index,
//                                            send_reply, last
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// In the receive states a byte is accepted whenever the output register is free.
// A good frame replays its payload byte by byte, each through S_READ then
// S_SEND (store read is registered), then sends the ACK item; rx_ready is low meanwhile.
// Asynchronous active-low reset restores the default markers and codes;
// the payload store is not cleared. A stalled out_ready holds the replay
// and keeps rx_ready low while the output register is full.
module serial_frame_receiver_top #(
    parameter int PAYLOAD_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sfr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                        rx_valid,
    output logic                        rx_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sfr_pkg::STAT_W-1:0]  status,
    output logic [sfr_pkg::BYTE_W-1:0]  data_byte,
    output logic [sfr_pkg::INDEX_W-1:0] byte_index,
    output logic                        send_reply,
    output logic                        last
);

    sfr_pkg::cmd_t cmd;
    sfr_pkg::sts_t sts;

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfr_dp #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .send_reply (send_reply),
        .last       (last)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load && out_valid && !out_ready))
        else $error("output item overwritten before it was taken");

    a_no_rx_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_ready && (cmd.rd_en || cmd.idx_inc)))
        else $error("receive enabled during payload replay");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == sfr_pkg::OUT_PAYLOAD)) |-> (!last && !send_reply))
        else $error("payload item flagged as last or reply");

endmodule
